>>> sv/rgc_pkg.sv
// ----------------------------------------------------------------------------
// rgc_pkg
// shared constants, types and rounding helper for the recursive gaussian
// coefficient generator
// ----------------------------------------------------------------------------
package rgc_pkg;

   // q30 constants
   localparam logic [30:0] QONE    = 31'd1073741824;
   localparam logic [29:0] C_LIN_A = 30'd1059901292;
   localparam logic [29:0] C_LIN_B = 30'd1034335499;
   localparam logic [31:0] C_SQ_A  = 32'd4264430079;
   localparam logic [32:0] C_SQ_B  = 33'd4451239681;
   localparam logic [28:0] C_SQ_C  = 29'd288739914;
   localparam logic [30:0] C_K0    = 31'd1694633034;
   localparam logic [31:0] C_K1    = 32'd2624364604;
   localparam logic [30:0] C_K2    = 31'd1533410699;
   localparam logic [28:0] C_K3    = 29'd453339167;
   localparam logic [31:0] C_M2    = 32'd3066810660;
   localparam logic [30:0] C_M3    = 31'd1360012132;

   localparam int Q_W        = 42;
   localparam int S_W        = 4;
   localparam int QS_W       = 30;
   localparam int P_W        = 31;
   localparam int RAD_W      = 31;
   localparam int ROOT_W     = 31;
   localparam int X_W        = 62;
   localparam int TERM_W     = 34;
   localparam int NUM_W      = 36;
   localparam int DEN_W      = 34;
   localparam int QUO_W      = 20;
   localparam int OUT_W      = 20;
   localparam int SQRT_STEPS = 31;
   localparam int FRONT_LAT  = 2;
   localparam int POLY_LAT   = 6;
   localparam int LATENCY    = FRONT_LAT + SQRT_STEPS + POLY_LAT + QUO_W + 2;

   localparam logic [OUT_W-1:0] OUT_MAX = 20'h7FFFF;
   localparam logic [OUT_W-1:0] OUT_MIN = 20'h80000;

   typedef struct packed {
      logic signed [NUM_W-1:0] gain;
      logic signed [NUM_W-1:0] one;
      logic signed [NUM_W-1:0] two;
      logic signed [NUM_W-1:0] three;
      logic [DEN_W-1:0]        den;
   } num_set_type;

   // round to nearest, then shift right
   function automatic logic [63:0] rnd_sh(input logic [63:0] x, input logic [6:0] n);
      logic [64:0] t;
      t = {1'b0, x} + (65'd1 << (n - 7'd1));
      if (n == 7'd0) begin
         return x;
      end
      return 64'(t >> n);
   endfunction

endpackage

>>> sv/recursive_gaussian_coefficients.sv
// ----------------------------------------------------------------------------
// recursive_gaussian_coefficients
// young - van vliet coefficients (gain and three feedback taps) from sigma
// ----------------------------------------------------------------------------
// takes one sigma per clock and returns its four coefficients as a
// single-cycle rsp_valid strobe; busy is always low and results cannot be
// held off, so capture them on the strobe. requests pass through the front,
// the 31-stage square root, the polynomial stages and four 22-stage dividers.
// ----------------------------------------------------------------------------
module recursive_gaussian_coefficients import rgc_pkg::*; #(
   parameter int SIGMA_FRAC_BITS = 8,
   parameter int COEF_FRAC_BITS  = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [15:0]       req_sigma,
   output logic                     rsp_valid,
   output logic signed [OUT_W-1:0]  rsp_gain,
   output logic signed [OUT_W-1:0]  rsp_tap_one,
   output logic signed [OUT_W-1:0]  rsp_tap_two,
   output logic signed [OUT_W-1:0]  rsp_tap_three
);

   logic              f_valid, f_lin, s_valid, s_lin, p_valid;
   logic [Q_W-1:0]    f_q_lin, s_q_lin;
   logic [RAD_W-1:0]  f_rad;
   logic [ROOT_W-1:0] s_root;
   num_set_type       p_nums;
   logic              v_one, v_two, v_three;

   assign busy = 1'b0;

   rgc_front #(.SIGMA_FRAC_BITS(SIGMA_FRAC_BITS)) u_front (
      .clock, .reset,
      .in_valid(start), .in_sigma(req_sigma),
      .out_valid(f_valid), .out_lin(f_lin), .out_q_lin(f_q_lin), .out_rad(f_rad)
   );

   rgc_sqrt u_sqrt (
      .clock, .reset,
      .in_valid(f_valid), .in_lin(f_lin), .in_q_lin(f_q_lin), .in_rad(f_rad),
      .out_valid(s_valid), .out_lin(s_lin), .out_q_lin(s_q_lin), .out_root(s_root)
   );

   rgc_poly u_poly (
      .clock, .reset,
      .in_valid(s_valid), .in_lin(s_lin), .in_q_lin(s_q_lin), .in_root(s_root),
      .out_valid(p_valid), .out_nums(p_nums)
   );

   rgc_div #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_div_gain (
      .clock, .reset, .in_valid(p_valid), .in_num(p_nums.gain), .in_den(p_nums.den),
      .out_valid(rsp_valid), .out_value(rsp_gain)
   );

   rgc_div #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_div_one (
      .clock, .reset, .in_valid(p_valid), .in_num(p_nums.one), .in_den(p_nums.den),
      .out_valid(v_one), .out_value(rsp_tap_one)
   );

   rgc_div #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_div_two (
      .clock, .reset, .in_valid(p_valid), .in_num(p_nums.two), .in_den(p_nums.den),
      .out_valid(v_two), .out_value(rsp_tap_two)
   );

   rgc_div #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_div_three (
      .clock, .reset, .in_valid(p_valid), .in_num(p_nums.three), .in_den(p_nums.den),
      .out_valid(v_three), .out_value(rsp_tap_three)
   );

   a_latency : assert property (@(posedge clock) disable iff (reset)
      start |-> ##LATENCY rsp_valid)
      else $error("request lost in pipeline");

   a_lanes : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid == v_one) && (rsp_valid == v_two) && (rsp_valid == v_three))
      else $error("divider lanes out of step");

   a_tap_three_sign : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_tap_three[OUT_W-1])
      else $error("tap three negative");

   a_tap_two_sign : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_tap_two[OUT_W-1] || (rsp_tap_two == '0)))
      else $error("tap two positive");

endmodule

>>> sv/rgc_front.sv
// ----------------------------------------------------------------------------
// rgc_front
// sigma magnitude, branch select, linear q and square root radicand
// ----------------------------------------------------------------------------
module rgc_front import rgc_pkg::*; #(
   parameter int SIGMA_FRAC_BITS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic signed [15:0]       in_sigma,
   output logic                     out_valid,
   output logic                     out_lin,
   output logic [Q_W-1:0]           out_q_lin,
   output logic [RAD_W-1:0]         out_rad
);

   localparam logic [16:0] THR = 17'(5 << SIGMA_FRAC_BITS);
   localparam logic [6:0]  SH  = 7'(SIGMA_FRAC_BITS);

   logic [15:0]       neg_v;
   logic [14:0]       a_in, a_ff;
   logic              v1_ff, v2_ff, lin1_ff, lin2_ff;
   logic [Q_W-1:0]    q_lin_in, q_lin_ff;
   logic [RAD_W-1:0]  rad_in, rad_ff;

   always_comb begin
      neg_v = 16'(~in_sigma + 16'sd1);
      if (in_sigma[15]) begin
         a_in = neg_v[15] ? 15'h7FFF : neg_v[14:0];
      end else begin
         a_in = in_sigma[14:0];
      end
      q_lin_in = Q_W'(rnd_sh(64'(C_LIN_A) * 64'(a_ff), SH) - 64'(C_LIN_B));
      rad_in   = RAD_W'(64'(QONE) - rnd_sh(64'(C_SQ_C) * 64'(a_ff), SH));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      a_ff     <= a_in;
      lin1_ff  <= {a_in, 1'b0} >= THR;
      lin2_ff  <= lin1_ff;
      q_lin_ff <= q_lin_in;
      rad_ff   <= rad_in;
   end

   assign out_valid = v2_ff;
   assign out_lin   = lin2_ff;
   assign out_q_lin = q_lin_ff;
   assign out_rad   = rad_ff;

endmodule

>>> sv/rgc_sqrt.sv
// ----------------------------------------------------------------------------
// rgc_sqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module rgc_sqrt import rgc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic                in_lin,
   input  logic [Q_W-1:0]      in_q_lin,
   input  logic [RAD_W-1:0]    in_rad,
   output logic                out_valid,
   output logic                out_lin,
   output logic [Q_W-1:0]      out_q_lin,
   output logic [ROOT_W-1:0]   out_root
);

   logic [X_W-1:0]  x_src   [SQRT_STEPS+1];
   logic [X_W-1:0]  r_src   [SQRT_STEPS+1];
   logic            v_src   [SQRT_STEPS+1];
   logic            l_src   [SQRT_STEPS+1];
   logic [Q_W-1:0]  q_src   [SQRT_STEPS+1];
   logic [X_W-1:0]  x_ff    [SQRT_STEPS];
   logic [X_W-1:0]  r_ff    [SQRT_STEPS];
   logic            v_ff    [SQRT_STEPS];
   logic            l_ff    [SQRT_STEPS];
   logic [Q_W-1:0]  q_ff    [SQRT_STEPS];

   assign x_src[0] = {1'b0, in_rad, 30'd0};
   assign r_src[0] = '0;
   assign v_src[0] = in_valid;
   assign l_src[0] = in_lin;
   assign q_src[0] = in_q_lin;

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      localparam logic [X_W-1:0] BIT = X_W'(1) << (2 * (SQRT_STEPS - 1 - k));
      logic [X_W-1:0] sum, x_in, r_in;
      logic           ge;

      always_comb begin
         sum  = r_src[k] + BIT;
         ge   = x_src[k] >= sum;
         x_in = ge ? x_src[k] - sum : x_src[k];
         r_in = ge ? (r_src[k] >> 1) + BIT : r_src[k] >> 1;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else begin
            v_ff[k] <= v_src[k];
         end
         x_ff[k] <= x_in;
         r_ff[k] <= r_in;
         l_ff[k] <= l_src[k];
         q_ff[k] <= q_src[k];
      end

      assign x_src[k+1] = x_ff[k];
      assign r_src[k+1] = r_ff[k];
      assign v_src[k+1] = v_ff[k];
      assign l_src[k+1] = l_ff[k];
      assign q_src[k+1] = q_ff[k];
   end

   assign out_valid = v_src[SQRT_STEPS];
   assign out_lin   = l_src[SQRT_STEPS];
   assign out_q_lin = q_src[SQRT_STEPS];
   assign out_root  = ROOT_W'(r_src[SQRT_STEPS]);

endmodule

>>> sv/rgc_poly.sv
// ----------------------------------------------------------------------------
// rgc_poly
// q select and scaling, cubic terms, numerators and divisor b0
// ----------------------------------------------------------------------------
module rgc_poly import rgc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic               in_lin,
   input  logic [Q_W-1:0]     in_q_lin,
   input  logic [ROOT_W-1:0]  in_root,
   output logic               out_valid,
   output num_set_type        out_nums
);

   logic               v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic               lin1_ff;
   logic [Q_W-1:0]     qlin1_ff, q_sel;
   logic [32:0]        prod_in, prod_ff;
   logic [S_W-1:0]     s_in, s2_ff, s3_ff;
   logic [QS_W-1:0]    qs_in, qs2_ff, qs3_ff;
   logic [P_W-1:0]     p2_in, p2_ff, p3_in, p3_ff;
   logic [6:0]         sh1, sh2, sh3;
   logic [TERM_W-1:0]  t1_in, t2_in, m2_in, k0_in, t3_in, m3_in;
   logic [TERM_W-1:0]  t1_ff, t2_ff, m2_ff, k0_ff;
   logic [TERM_W-1:0]  t1b_ff, t2b_ff, m2b_ff, k0b_ff, t3_ff, m3_ff;
   logic signed [NUM_W-1:0] b0, b1, b2m, b3;
   num_set_type        nums_in, nums_ff;

   always_comb begin
      prod_in = 33'(rnd_sh(64'(C_SQ_B) * 64'(in_root), 7'd30));

      if (lin1_ff) begin
         q_sel = qlin1_ff;
      end else if (33'(C_SQ_A) > prod_ff) begin
         q_sel = Q_W'(33'(C_SQ_A) - prod_ff);
      end else begin
         q_sel = '0;
      end
      s_in = '0;
      for (int i = QS_W; i < Q_W; i++) begin
         if (q_sel[i]) begin
            s_in = S_W'(i - QS_W + 1);
         end
      end
      qs_in = QS_W'(q_sel >> s_in);

      p2_in = P_W'(rnd_sh(64'(qs2_ff) * 64'(qs2_ff), 7'd30));

      sh1   = 7'(s3_ff);
      sh2   = 7'({s3_ff, 1'b0});
      sh3   = sh1 + sh2;
      p3_in = P_W'(rnd_sh(64'(p2_ff) * 64'(qs3_ff), 7'd30));
      t1_in = TERM_W'(rnd_sh(64'(C_K1) * 64'(qs3_ff), 7'd30 + sh2));
      t2_in = TERM_W'(rnd_sh(64'(C_K2) * 64'(p2_ff), 7'd30 + sh1));
      m2_in = TERM_W'(rnd_sh(64'(C_M2) * 64'(p2_ff), 7'd30 + sh1));
      k0_in = TERM_W'(rnd_sh(64'(C_K0), sh3));

      t3_in = TERM_W'(rnd_sh(64'(C_K3) * 64'(p3_ff), 7'd30));
      m3_in = TERM_W'(rnd_sh(64'(C_M3) * 64'(p3_ff), 7'd30));

      b0  = NUM_W'(k0b_ff) + NUM_W'(t1b_ff) + NUM_W'(t2b_ff) + NUM_W'(t3_ff);
      b1  = NUM_W'(t1b_ff) + NUM_W'(m2b_ff) + NUM_W'(m3_ff);
      b2m = NUM_W'(t2b_ff) + NUM_W'(m3_ff);
      b3  = NUM_W'(t3_ff);
      nums_in.gain  = b0 - b1 + b2m - b3;
      nums_in.one   = b1;
      nums_in.two   = -b2m;
      nums_in.three = b3;
      nums_in.den   = DEN_W'(b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
      lin1_ff  <= in_lin;
      qlin1_ff <= in_q_lin;
      prod_ff  <= prod_in;
      s2_ff    <= s_in;
      qs2_ff   <= qs_in;
      s3_ff    <= s2_ff;
      qs3_ff   <= qs2_ff;
      p2_ff    <= p2_in;
      p3_ff    <= p3_in;
      t1_ff    <= t1_in;
      t2_ff    <= t2_in;
      m2_ff    <= m2_in;
      k0_ff    <= k0_in;
      t1b_ff   <= t1_ff;
      t2b_ff   <= t2_ff;
      m2b_ff   <= m2_ff;
      k0b_ff   <= k0_ff;
      t3_ff    <= t3_in;
      m3_ff    <= m3_in;
      nums_ff  <= nums_in;
   end

   assign out_valid = v6_ff;
   assign out_nums  = nums_ff;

endmodule

>>> sv/rgc_div.sv
// ----------------------------------------------------------------------------
// rgc_div
// pipelined rounded ratio num / den with saturation, one quotient bit per stage
// ----------------------------------------------------------------------------
module rgc_div import rgc_pkg::*; #(
   parameter int COEF_FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic signed [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]         in_den,
   output logic                     out_valid,
   output logic signed [OUT_W-1:0]  out_value
);

   localparam int N_W   = NUM_W + COEF_FRAC_BITS;
   localparam int HI_W  = N_W - QUO_W;
   localparam int REM_W = DEN_W + 1;
   localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

   logic                neg0_in;
   logic [NUM_W-2:0]    mag0;
   logic [N_W-1:0]      nval;
   logic [HI_W-1:0]     hi;
   logic                sat0_in, zero0_in;

   logic [REM_W-1:0]    rem_src [QUO_W+1];
   logic [QUO_W-1:0]    lq_src  [QUO_W+1];
   logic                v_src   [QUO_W+1];
   logic [REM_W-1:0]    rem_ff  [QUO_W+1];
   logic [QUO_W-1:0]    lq_ff   [QUO_W+1];
   logic                v_ff    [QUO_W+1];
   logic [DEN_W-1:0]    den_ff  [QUO_W+1];
   logic                neg_ff  [QUO_W+1];
   logic                sat_ff  [QUO_W+1];
   logic                zero_ff [QUO_W+1];

   logic [OUT_W-1:0]    value_in, value_ff;
   logic                valid_ff;

   always_comb begin
      neg0_in  = in_num[NUM_W-1];
      mag0     = (NUM_W-1)'(neg0_in ? -in_num : in_num);
      nval     = (N_W'(mag0) << COEF_FRAC_BITS) + N_W'(in_den >> 1);
      hi       = nval[N_W-1:QUO_W];
      zero0_in = in_den == '0;
      sat0_in  = CMP_W'(hi) >= CMP_W'(in_den);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
      end
      rem_ff[0]  <= REM_W'(hi);
      lq_ff[0]   <= nval[QUO_W-1:0];
      den_ff[0]  <= in_den;
      neg_ff[0]  <= neg0_in;
      sat_ff[0]  <= sat0_in;
      zero_ff[0] <= zero0_in;
   end

   for (genvar k = 0; k < QUO_W; k++) begin : g_step
      logic [REM_W-1:0] cand, rem_in;
      logic             ge;

      always_comb begin
         cand   = {rem_ff[k][REM_W-2:0], lq_ff[k][QUO_W-1]};
         ge     = cand >= {1'b0, den_ff[k]};
         rem_in = ge ? cand - {1'b0, den_ff[k]} : cand;
      end

      assign rem_src[k+1] = rem_in;
      assign lq_src[k+1]  = {lq_ff[k][QUO_W-2:0], ge};
      assign v_src[k+1]   = v_ff[k];

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else begin
            v_ff[k+1] <= v_src[k+1];
         end
         rem_ff[k+1]  <= rem_src[k+1];
         lq_ff[k+1]   <= lq_src[k+1];
         den_ff[k+1]  <= den_ff[k];
         neg_ff[k+1]  <= neg_ff[k];
         sat_ff[k+1]  <= sat_ff[k];
         zero_ff[k+1] <= zero_ff[k];
      end
   end

   assign rem_src[0] = rem_ff[0];
   assign lq_src[0]  = lq_ff[0];
   assign v_src[0]   = v_ff[0];

   always_comb begin
      if (zero_ff[QUO_W]) begin
         value_in = '0;
      end else if (sat_ff[QUO_W]) begin
         value_in = neg_ff[QUO_W] ? OUT_MIN : OUT_MAX;
      end else if (neg_ff[QUO_W]) begin
         value_in = lq_ff[QUO_W][QUO_W-1] ? OUT_MIN : OUT_W'(-lq_ff[QUO_W]);
      end else begin
         value_in = lq_ff[QUO_W][QUO_W-1] ? OUT_MAX : OUT_W'(lq_ff[QUO_W]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= v_ff[QUO_W];
      end
      value_ff <= value_in;
   end

   assign out_valid = valid_ff;
   assign out_value = value_ff;

endmodule
